// ----- hdl/bsd_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte-stuffing deframer package
// Shared constants and the result type of the deframer.
// ----------------------------------------------------------------------------
package bsd_pkg;

   localparam int MAX_DATA = 1024;
   localparam int COUNT_W  = $clog2(MAX_DATA + 1);
   localparam int INDEX_W  = 10;

   localparam logic [7:0] ESC_BYTE = 8'h01;
   localparam logic [7:0] END_BYTE = 8'h00;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_DATA);

   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic [7:0]         receiver_id;
      logic [7:0]         packet_type;
      logic [7:0]         sender_id;
      logic [7:0]         sequence_number;
      logic [7:0]         payload_byte;
      logic               byte_valid;
      logic [INDEX_W-1:0] byte_index;
      logic               packet_done;
      logic               truncated;
      logic               overflowed;
   } result_type;

endpackage

// ----- hdl/bsd_channels.sv -----
// ----------------------------------------------------------------------------
// Byte-stuffing deframer channels
// Valid/ready interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
interface bsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       msg_end;

   modport source (output valid, output in_byte, output msg_end, input ready);
   modport sink (input valid, input in_byte, input msg_end, output ready);
endinterface

interface bsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] receiver_id;
   logic [7:0] packet_type;
   logic [7:0] sender_id;
   logic [7:0] sequence_number;
   logic [7:0] payload_byte;
   logic       byte_valid;
   logic [9:0] byte_index;
   logic       packet_done;
   logic       truncated;
   logic       overflowed;

   modport source (
      output valid, output receiver_id, output packet_type, output sender_id,
      output sequence_number, output payload_byte, output byte_valid,
      output byte_index, output packet_done, output truncated, output overflowed,
      input ready
   );
   modport sink (
      input valid, input receiver_id, input packet_type, input sender_id,
      input sequence_number, input payload_byte, input byte_valid,
      input byte_index, input packet_done, input truncated, input overflowed,
      output ready
   );
endinterface

// ----- hdl/byte_stuffing_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// Byte-stuffing deframer
// Strips a four-byte header, removes escape bytes and splits packets on the
// terminator byte or message end; emits data bytes up to MAX_DATA with header.
//
//   channel   direction  handshake      payload
//   req_if    in         valid/ready    in_byte, msg_end
//   rsp_if    out        valid/ready    header bytes, data byte, flags
//
// One byte is accepted per cycle; its result, if any, appears in the result
// register on the next cycle. The result register is the only pipeline stage,
// so a byte is accepted whenever the register is empty or being drained.
// Reset is synchronous and returns the parser to awaiting header byte 0.
// ----------------------------------------------------------------------------
module byte_stuffing_deframer_unit (
   input logic    clock,
   input logic    reset,
   bsd_req_if.sink   req_if,
   bsd_rsp_if.source rsp_if
);
   import bsd_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_HDR2 = 3'd2,
      PH_HDR3 = 3'd3,
      PH_DATA = 3'd4,
      PH_ESC  = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] header_ff [4];
   logic [7:0] header_in [4];
   count_type  count_ff, count_in;
   logic       ovf_ff, ovf_in;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff, result_in;

   logic       req_fire;
   logic       emit;
   logic       emit_valid;
   logic       emit_done;
   logic       emit_trunc;
   logic       emit_ovf;
   logic [1:0] hdr_pos;
   logic [7:0] in_byte;
   logic       last;
   logic       room;
   logic [COUNT_W+INDEX_W-1:0] count_ext;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign in_byte      = req_if.msg_end ? req_if.in_byte : req_if.in_byte;
   assign last         = req_if.msg_end;
   assign room         = count_ff < COUNT_MAX;
   assign count_ext    = {{INDEX_W{1'b0}}, count_ff};

   always_comb begin
      phase_in   = phase_ff;
      header_in  = header_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      emit       = 1'b0;
      emit_valid = 1'b0;
      emit_done  = 1'b0;
      emit_trunc = 1'b0;
      emit_ovf   = ovf_ff;
      hdr_pos    = 2'd0;

      unique case (phase_ff) inside
         PH_DATA, PH_ESC: begin
            if (phase_ff == PH_DATA && in_byte == ESC_BYTE) begin
               if (last) begin
                  emit       = 1'b1;
                  emit_done  = 1'b1;
                  emit_trunc = 1'b1;
               end else begin
                  phase_in = PH_ESC;
               end
            end else if (phase_ff == PH_DATA && in_byte == END_BYTE) begin
               emit      = 1'b1;
               emit_done = 1'b1;
            end else begin
               phase_in = PH_DATA;
               if (room) begin
                  emit       = 1'b1;
                  emit_valid = 1'b1;
                  emit_done  = last;
                  count_in   = count_ff + COUNT_W'(1);
               end else begin
                  ovf_in   = 1'b1;
                  emit_ovf = 1'b1;
                  emit     = last;
                  emit_done = last;
               end
            end
            if (emit_done) begin
               phase_in = PH_HDR0;
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            unique case (phase_ff)
               PH_HDR1: hdr_pos = 2'd1;
               PH_HDR2: hdr_pos = 2'd2;
               PH_HDR3: hdr_pos = 2'd3;
               default: hdr_pos = 2'd0;
            endcase
            if (hdr_pos == 2'd0) begin
               for (int i = 0; i < 4; i++) begin
                  header_in[i] = 8'h00;
               end
               count_in = '0;
               ovf_in   = 1'b0;
               emit_ovf = 1'b0;
            end
            header_in[hdr_pos] = in_byte;
            if (last) begin
               emit       = 1'b1;
               emit_done  = 1'b1;
               emit_trunc = hdr_pos != 2'd3;
               phase_in   = PH_HDR0;
               count_in   = '0;
               ovf_in     = 1'b0;
            end else begin
               unique case (hdr_pos)
                  2'd0:    phase_in = PH_HDR1;
                  2'd1:    phase_in = PH_HDR2;
                  2'd2:    phase_in = PH_HDR3;
                  default: phase_in = PH_DATA;
               endcase
            end
         end
      endcase
   end

   always_comb begin
      result_in.receiver_id     = header_in[0];
      result_in.packet_type     = header_in[1];
      result_in.sender_id       = header_in[2];
      result_in.sequence_number = header_in[3];
      result_in.payload_byte    = emit_valid ? in_byte : 8'h00;
      result_in.byte_valid      = emit_valid;
      result_in.byte_index      = emit_valid ? count_ext[INDEX_W-1:0] : '0;
      result_in.packet_done     = emit_done;
      result_in.truncated       = emit_trunc;
      result_in.overflowed      = emit_ovf;

      if (req_fire) begin
         rsp_valid_in = emit;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         result_ff    <= '0;
         for (int i = 0; i < 4; i++) begin
            header_ff[i] <= 8'h00;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            ovf_ff    <= ovf_in;
            header_ff <= header_in;
         end
         if (req_fire && emit) begin
            result_ff <= result_in;
         end
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.receiver_id     = result_ff.receiver_id;
   assign rsp_if.packet_type     = result_ff.packet_type;
   assign rsp_if.sender_id       = result_ff.sender_id;
   assign rsp_if.sequence_number = result_ff.sequence_number;
   assign rsp_if.payload_byte    = result_ff.payload_byte;
   assign rsp_if.byte_valid      = result_ff.byte_valid;
   assign rsp_if.byte_index      = result_ff.byte_index;
   assign rsp_if.packet_done     = result_ff.packet_done;
   assign rsp_if.truncated       = result_ff.truncated;
   assign rsp_if.overflowed      = result_ff.overflowed;

endmodule
